// ===== design/fdc_pkg.sv =====
`timescale 1ns / 1ps

package fdc_pkg;

  localparam int COUNT_BITS = 32;
  localparam int ADC_BITS   = 10;

  // error path width: sum of two counts plus the negation headroom
  localparam int ERR_W  = COUNT_BITS + 2;
  localparam int GAIN_W = 8;
  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int TERM_W = 9;
  localparam int DRV_W  = 10;
  localparam int SPD_W  = 8;

  localparam int TGT_W  = 20;
  localparam int BAND_W = 16;
  localparam int CFG_W  = 20;

  localparam logic [GAIN_W-1:0] DIST_LIMIT     = 8'd150;
  localparam logic [GAIN_W-1:0] MISMATCH_LIMIT = 8'd50;
  localparam logic [GAIN_W-1:0] WALL_LIMIT     = 8'd50;

  localparam logic [TGT_W-1:0]    TARGET_RST    = 20'd1090;
  localparam logic [BAND_W-1:0]   BAND_RST      = 16'd50;
  localparam logic [ADC_BITS-1:0] THRESH_RST    = 10'd200;
  localparam logic [ADC_BITS-1:0] NO_WALL_RST   = 10'd700;
  localparam logic [GAIN_W-1:0]   DIST_GAIN_RST = 8'd16;
  localparam logic [GAIN_W-1:0]   PAIR_GAIN_RST = 8'd32;

  typedef enum logic [2:0] {
    CFG_TARGET   = 3'd0,
    CFG_BAND     = 3'd1,
    CFG_R_THRESH = 3'd2,
    CFG_L_THRESH = 3'd3,
    CFG_NO_WALL  = 3'd4,
    CFG_D_GAIN   = 3'd5,
    CFG_M_GAIN   = 3'd6,
    CFG_W_GAIN   = 3'd7
  } cfg_idx_e;

  // gain (Q4.4) times error, truncated toward zero, clamped to +-limit
  function automatic logic signed [TERM_W-1:0] p_term(
    input logic [GAIN_W-1:0]      gain,
    input logic signed [ERR_W-1:0] err,
    input logic [GAIN_W-1:0]      limit
  );
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] quot;
    logic signed [PROD_W-1:0] lim;
    logic signed [TERM_W-1:0] res;
    prod = $signed({1'b0, gain}) * err;
    bias = $signed({{(PROD_W-4){1'b0}}, {4{prod[PROD_W-1]}}});
    quot = (prod + bias) >>> 4;
    lim  = $signed({{(PROD_W-GAIN_W){1'b0}}, limit});
    if (quot > lim) begin
      res = $signed({1'b0, limit});
    end else if (quot < -lim) begin
      res = -$signed({1'b0, limit});
    end else begin
      res = quot[TERM_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/forward_drive_controller.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake                  payload
// in        in   in_valid_i / in_ready_o    right_count_i, left_count_raw_i,
//                                           right_ir_level_i, left_ir_level_i
// out       out  out_valid_o / out_ready_i  right_speed_o, right_forward_o,
//                                           left_speed_o, left_forward_o, move_done_o
// cfg       in   cfg_we_i                   cfg_idx_i, cfg_data_i
//
// two-stage pipeline: errors and done band in stage one, gain multiplies,
// clamps and mixing in stage two; one item per cycle while the output is not stalled.
// the 9x34 gain multiplier in stage two sets the critical path.
// rst_ni clears the valid bits and loads the register defaults.
// an output stall holds the output stage, and stage one too when it is full; in_ready_o drops only when both are full.

module forward_drive_controller
  import fdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COUNT_BITS-1:0] right_count_i,
  input  logic [COUNT_BITS-1:0] left_count_raw_i,
  input  logic [ADC_BITS-1:0]   right_ir_level_i,
  input  logic [ADC_BITS-1:0]   left_ir_level_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SPD_W-1:0]      right_speed_o,
  output logic                  right_forward_o,
  output logic [SPD_W-1:0]      left_speed_o,
  output logic                  left_forward_o,
  output logic                  move_done_o
);

  logic [TGT_W-1:0]    target_q;
  logic [BAND_W-1:0]   band_q;
  logic [ADC_BITS-1:0] r_thresh_q, l_thresh_q, no_wall_q;
  logic [GAIN_W-1:0]   d_gain_q, m_gain_q, w_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TARGET_RST;
      band_q     <= BAND_RST;
      r_thresh_q <= THRESH_RST;
      l_thresh_q <= THRESH_RST;
      no_wall_q  <= NO_WALL_RST;
      d_gain_q   <= DIST_GAIN_RST;
      m_gain_q   <= PAIR_GAIN_RST;
      w_gain_q   <= PAIR_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET:   target_q   <= cfg_data_i[TGT_W-1:0];
        CFG_BAND:     band_q     <= cfg_data_i[BAND_W-1:0];
        CFG_R_THRESH: r_thresh_q <= cfg_data_i[ADC_BITS-1:0];
        CFG_L_THRESH: l_thresh_q <= cfg_data_i[ADC_BITS-1:0];
        CFG_NO_WALL:  no_wall_q  <= cfg_data_i[ADC_BITS-1:0];
        CFG_D_GAIN:   d_gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_M_GAIN:   m_gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_W_GAIN:   w_gain_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q, out_valid_q;
  logic out_en, s1_en;

  assign out_en     = !out_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || out_en;
  assign in_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // stage one: errors
  logic signed [ERR_W-1:0]    r_ext, l_ext, sum, travelled;
  logic signed [ERR_W-1:0]    dist_err_d, mismatch_d;
  logic [ERR_W-1:0]           abs_err;
  logic [ADC_BITS-1:0]        r_ir, l_ir;
  logic signed [ADC_BITS:0]   wall_err_d;
  logic                       done_d;

  always_comb begin
    r_ext = ERR_W'($signed(right_count_i));
    l_ext = -ERR_W'($signed(left_count_raw_i));
    sum   = r_ext + l_ext;
    // halve toward zero
    travelled  = (sum + $signed({{(ERR_W-1){1'b0}}, sum[ERR_W-1]})) >>> 1;
    dist_err_d = $signed({{(ERR_W-TGT_W){1'b0}}, target_q}) - travelled;
    mismatch_d = r_ext - l_ext;
    abs_err    = dist_err_d[ERR_W-1] ? ERR_W'(-dist_err_d) : ERR_W'(dist_err_d);
    done_d     = abs_err <= {{(ERR_W-BAND_W){1'b0}}, band_q};
    r_ir       = (right_ir_level_i < r_thresh_q) ? no_wall_q : right_ir_level_i;
    l_ir       = (left_ir_level_i < l_thresh_q) ? no_wall_q : left_ir_level_i;
    wall_err_d = $signed({1'b0, r_ir}) - $signed({1'b0, l_ir});
  end

  logic signed [ERR_W-1:0]  s1_dist_err_q, s1_mismatch_q;
  logic signed [ADC_BITS:0] s1_wall_err_q;
  logic                     s1_done_q;

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_dist_err_q <= dist_err_d;
      s1_mismatch_q <= mismatch_d;
      s1_wall_err_q <= wall_err_d;
      s1_done_q     <= done_d;
    end
  end

  // stage two: proportional terms and mixing
  logic signed [TERM_W-1:0] d_term, m_term, w_term;
  logic signed [DRV_W-1:0]  left_drive, right_drive;
  logic [DRV_W-1:0]         left_mag, right_mag;
  logic [SPD_W-1:0]         r_speed_d, l_speed_d;
  logic                     r_fwd_d, l_fwd_d;

  always_comb begin
    d_term      = p_term(d_gain_q, s1_dist_err_q, DIST_LIMIT);
    m_term      = p_term(m_gain_q, s1_mismatch_q, MISMATCH_LIMIT);
    w_term      = p_term(w_gain_q, ERR_W'(s1_wall_err_q), WALL_LIMIT);
    left_drive  = DRV_W'(d_term) + DRV_W'(m_term) - DRV_W'(w_term);
    right_drive = DRV_W'(d_term) - DRV_W'(m_term) + DRV_W'(w_term);
    left_mag    = left_drive[DRV_W-1] ? DRV_W'(-left_drive) : DRV_W'(left_drive);
    right_mag   = right_drive[DRV_W-1] ? DRV_W'(-right_drive) : DRV_W'(right_drive);
    if (s1_done_q) begin
      r_speed_d = '0;
      l_speed_d = '0;
      r_fwd_d   = 1'b1;
      l_fwd_d   = 1'b1;
    end else begin
      r_speed_d = right_mag[SPD_W-1:0];
      l_speed_d = left_mag[SPD_W-1:0];
      r_fwd_d   = !right_drive[DRV_W-1];
      l_fwd_d   = !left_drive[DRV_W-1];
    end
  end

  logic [SPD_W-1:0] r_speed_q, l_speed_q;
  logic             r_fwd_q, l_fwd_q, done_q;

  always_ff @(posedge clk_i) begin
    if (out_en && s1_valid_q) begin
      r_speed_q <= r_speed_d;
      l_speed_q <= l_speed_d;
      r_fwd_q   <= r_fwd_d;
      l_fwd_q   <= l_fwd_d;
      done_q    <= s1_done_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign right_speed_o   = r_speed_q;
  assign right_forward_o = r_fwd_q;
  assign left_speed_o    = l_speed_q;
  assign left_forward_o  = l_fwd_q;
  assign move_done_o     = done_q;

`ifndef SYNTHESIS
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && move_done_o |->
      right_speed_o == '0 && left_speed_o == '0 && right_forward_o && left_forward_o)
    else $error("done result with nonzero drive");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> right_speed_o <= SPD_W'(250) && left_speed_o <= SPD_W'(250))
    else $error("drive magnitude above 250");

  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a full pipeline");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_q)
    else $error("stage one item did not reach the output");
`endif

endmodule

// ===== bench/forward_drive_controller_tb.sv =====
`timescale 1ns / 1ps

module forward_drive_controller_tb;
  import fdc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 125;
  localparam int N_DIR       = 17;

  typedef struct packed {
    logic [SPD_W-1:0] right_speed;
    logic             right_fwd;
    logic [SPD_W-1:0] left_speed;
    logic             left_fwd;
    logic             done;
  } drive_t;

  typedef struct {
    logic [COUNT_BITS-1:0] rc;
    logic [COUNT_BITS-1:0] lc;
    logic [ADC_BITS-1:0]   rir;
    logic [ADC_BITS-1:0]   lir;
    bit                    typed;
    drive_t                res;
  } sample_row_t;

  localparam drive_t PARKED     = '{8'd0, 1'b1, 8'd0, 1'b1, 1'b1};
  localparam drive_t FULL_AHEAD = '{8'd150, 1'b1, 8'd150, 1'b1, 1'b0};
  localparam drive_t NO_RES     = '0;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [2:0]            cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [COUNT_BITS-1:0] right_count_i = '0;
  logic [COUNT_BITS-1:0] left_count_raw_i = '0;
  logic [ADC_BITS-1:0]   right_ir_level_i = '0;
  logic [ADC_BITS-1:0]   left_ir_level_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [SPD_W-1:0]      right_speed_o;
  logic                  right_forward_o;
  logic [SPD_W-1:0]      left_speed_o;
  logic                  left_forward_o;
  logic                  move_done_o;

  forward_drive_controller dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow copy of the register file
  logic [TGT_W-1:0]    tgt_cfg    = TARGET_RST;
  logic [BAND_W-1:0]   band_cfg   = BAND_RST;
  logic [ADC_BITS-1:0] rth_cfg    = THRESH_RST;
  logic [ADC_BITS-1:0] lth_cfg    = THRESH_RST;
  logic [ADC_BITS-1:0] nowall_cfg = NO_WALL_RST;
  logic [GAIN_W-1:0]   dgain_cfg  = DIST_GAIN_RST;
  logic [GAIN_W-1:0]   mgain_cfg  = PAIR_GAIN_RST;
  logic [GAIN_W-1:0]   wgain_cfg  = PAIR_GAIN_RST;

  drive_t pending_drives[$];
  drive_t got_drive;
  drive_t want_drive;
  int     fail_cnt  = 0;
  int     cycle_cnt = 0;
  bit     tx_calm   = 1'b0;
  bit     rx_calm   = 1'b0;
  int     rx_hold   = 0;

  sample_row_t dir_rows [N_DIR] = '{
    '{32'd0, 32'd0, 10'd0, 10'd0, 1'b1, FULL_AHEAD},
    '{32'd1090, -32'sd1090, 10'd500, 10'd500, 1'b1, PARKED},
    '{32'h7FFFFFFF, 32'h80000000, 10'h3FF, 10'h3FF, 1'b0, NO_RES},
    '{32'h80000000, 32'h7FFFFFFF, 10'h3FF, 10'h3FF, 1'b0, NO_RES},
    // done band edges on both sides of the target
    '{32'd1040, -32'sd1040, 10'd0, 10'd0, 1'b1, PARKED},
    '{32'd1039, -32'sd1039, 10'd0, 10'd0, 1'b0, NO_RES},
    '{32'd1140, -32'sd1140, 10'd0, 10'd0, 1'b1, PARKED},
    '{32'd1141, -32'sd1141, 10'd0, 10'd0, 1'b0, NO_RES},
    '{-32'sd3, 32'd0, 10'd600, 10'd600, 1'b0, NO_RES},
    // odd sum truncates down into the band
    '{32'd1041, -32'sd1040, 10'd0, 10'd0, 1'b1, PARKED},
    '{-32'sd1, 32'd0, 10'd0, 10'd0, 1'b0, NO_RES},
    // right drive lands on exactly zero
    '{32'd1003, -32'sd977, 10'd300, 10'd400, 1'b0, NO_RES},
    '{32'd0, 32'd0, 10'd200, 10'd199, 1'b0, NO_RES},
    '{32'd0, 32'd0, 10'd199, 10'd200, 1'b0, NO_RES},
    '{32'hAAAAAAAA, 32'h55555555, 10'h2AA, 10'h155, 1'b0, NO_RES},
    '{32'h55555555, 32'hAAAAAAAA, 10'h155, 10'h2AA, 1'b0, NO_RES},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 10'h3FF, 10'd0, 1'b0, NO_RES}
  };

  function automatic longint gain_term(logic [GAIN_W-1:0] gain, longint err, longint lim);
    longint t;
    t = (longint'(gain) * err) / 16;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t;
  endfunction

  function automatic drive_t predict_drive(logic [COUNT_BITS-1:0] rc,
                                           logic [COUNT_BITS-1:0] lc,
                                           logic [ADC_BITS-1:0] rir,
                                           logic [ADC_BITS-1:0] lir);
    longint r, l, dist_err, abs_err, d, m, w, ld, rd;
    logic [ADC_BITS-1:0] rv, lv;
    drive_t res;
    r = longint'($signed(rc));
    l = -longint'($signed(lc));
    dist_err = longint'(tgt_cfg) - (r + l) / 2;
    rv = (rir < rth_cfg) ? nowall_cfg : rir;
    lv = (lir < lth_cfg) ? nowall_cfg : lir;
    abs_err = (dist_err < 0) ? -dist_err : dist_err;
    if (abs_err <= longint'(band_cfg)) return PARKED;
    d = gain_term(dgain_cfg, dist_err, 150);
    m = gain_term(mgain_cfg, r - l, 50);
    w = gain_term(wgain_cfg, longint'(rv) - longint'(lv), 50);
    ld = d + m - w;
    rd = d - m + w;
    res.right_speed = SPD_W'((rd < 0) ? -rd : rd);
    res.right_fwd   = (rd >= 0);
    res.left_speed  = SPD_W'((ld < 0) ? -ld : ld);
    res.left_fwd    = (ld >= 0);
    res.done        = 1'b0;
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [CFG_W-1:0] rand_reg();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  function automatic logic [ADC_BITS-1:0] pick_ir(logic [ADC_BITS-1:0] th);
    int v;
    if ($urandom_range(0, 2) == 0) begin
      v = int'(th) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return ADC_BITS'(v);
    end
    return ADC_BITS'($urandom_range(0, 1023));
  endfunction

  task automatic flag_mismatch(string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("mismatch: %s", what);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    case (idx)
      CFG_TARGET:   tgt_cfg    = data[TGT_W-1:0];
      CFG_BAND:     band_cfg   = data[BAND_W-1:0];
      CFG_R_THRESH: rth_cfg    = data[ADC_BITS-1:0];
      CFG_L_THRESH: lth_cfg    = data[ADC_BITS-1:0];
      CFG_NO_WALL:  nowall_cfg = data[ADC_BITS-1:0];
      CFG_D_GAIN:   dgain_cfg  = data[GAIN_W-1:0];
      CFG_M_GAIN:   mgain_cfg  = data[GAIN_W-1:0];
      CFG_W_GAIN:   wgain_cfg  = data[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_settings(logic [CFG_W-1:0] tgt, logic [CFG_W-1:0] band,
                                logic [CFG_W-1:0] rth, logic [CFG_W-1:0] lth,
                                logic [CFG_W-1:0] nw, logic [CFG_W-1:0] dg,
                                logic [CFG_W-1:0] mg, logic [CFG_W-1:0] wg);
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_BAND, band);
    write_reg(CFG_R_THRESH, rth);
    write_reg(CFG_L_THRESH, lth);
    write_reg(CFG_NO_WALL, nw);
    write_reg(CFG_D_GAIN, dg);
    write_reg(CFG_M_GAIN, mg);
    write_reg(CFG_W_GAIN, wg);
    cfg_we_i = 1'b0;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic drain_pipe();
    in_valid_i = 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_sample(logic [COUNT_BITS-1:0] rc, logic [COUNT_BITS-1:0] lc,
                             logic [ADC_BITS-1:0] rir, logic [ADC_BITS-1:0] lir,
                             bit typed, drive_t typed_res);
    in_valid_i       = 1'b1;
    right_count_i    = rc;
    left_count_raw_i = lc;
    right_ir_level_i = rir;
    left_ir_level_i  = lir;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_drives.push_back(typed ? typed_res : predict_drive(rc, lc, rir, lir));
    @(negedge clk_i);
    if (!tx_calm && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
  endtask

  task automatic rand_sample(output logic [COUNT_BITS-1:0] rc,
                             output logic [COUNT_BITS-1:0] lc,
                             output logic [ADC_BITS-1:0] rir,
                             output logic [ADC_BITS-1:0] lir);
    longint span, mspan, sum, mm, r, l;
    if ($urandom_range(0, 3) == 0) begin
      rc = $urandom;
      lc = $urandom;
    end else begin
      // well-formed sample: travel near the target, small wheel mismatch
      case ($urandom_range(0, 2))
        0: span = longint'(band_cfg) + 2;
        1: span = 300;
        default: span = 1 << 20;
      endcase
      case ($urandom_range(0, 2))
        0: mspan = 3;
        1: mspan = 40;
        default: mspan = 2000;
      endcase
      sum = 2 * longint'(tgt_cfg) + longint'($urandom_range(0, 2 * span)) - span;
      mm  = longint'($urandom_range(0, 2 * mspan)) - mspan;
      r   = (sum + mm) / 2;
      l   = sum - r;
      rc  = COUNT_BITS'(r);
      lc  = COUNT_BITS'(-l);
    end
    rir = pick_ir(rth_cfg);
    lir = pick_ir(lth_cfg);
  endtask

  // output side stall pattern
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i = 1'b0;
        rx_hold--;
      end else begin
        out_ready_i = 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) rx_hold = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_drive = '{right_speed_o, right_forward_o, left_speed_o, left_forward_o,
                    move_done_o};
      if (pending_drives.size() == 0) begin
        flag_mismatch($sformatf("transfer with nothing pending: rs=%0d rf=%0d ls=%0d lf=%0d dn=%0d",
                                got_drive.right_speed, got_drive.right_fwd,
                                got_drive.left_speed, got_drive.left_fwd, got_drive.done));
      end else begin
        want_drive = pending_drives.pop_front();
        if (got_drive !== want_drive) begin
          flag_mismatch($sformatf("want rs=%0d rf=%0d ls=%0d lf=%0d dn=%0d, got rs=%0d rf=%0d ls=%0d lf=%0d dn=%0d",
                                  want_drive.right_speed, want_drive.right_fwd,
                                  want_drive.left_speed, want_drive.left_fwd,
                                  want_drive.done, got_drive.right_speed,
                                  got_drive.right_fwd, got_drive.left_speed,
                                  got_drive.left_fwd, got_drive.done));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stim
    logic [COUNT_BITS-1:0] rc, lc;
    logic [ADC_BITS-1:0]   rir, lir;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      send_sample(dir_rows[i].rc, dir_rows[i].lc, dir_rows[i].rir, dir_rows[i].lir,
                  dir_rows[i].typed, dir_rows[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_pipe();
      case (ph)
        0: apply_settings('0, '0, '0, '0, '0, '0, '0, '0);
        1: apply_settings('1, '1, '1, '1, '1, '1, '1, '1);
        5: apply_settings(CFG_W'(TARGET_RST), CFG_W'(BAND_RST), CFG_W'(THRESH_RST),
                          CFG_W'(THRESH_RST), CFG_W'(NO_WALL_RST), CFG_W'(DIST_GAIN_RST),
                          CFG_W'(PAIR_GAIN_RST), CFG_W'(PAIR_GAIN_RST));
        default: apply_settings(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                                rand_reg(), rand_reg(), rand_reg(), rand_reg());
      endcase
      // one phase runs back to back on both sides
      tx_calm = (ph == 3);
      rx_calm = (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == PHASE_ITEMS / 2) drain_pipe();
        rand_sample(rc, lc, rir, lir);
        send_sample(rc, lc, rir, lir, 1'b0, NO_RES);
      end
    end

    drain_pipe();
    repeat (6) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== forward_drive_controller.f =====
design/fdc_pkg.sv
design/forward_drive_controller.sv
bench/forward_drive_controller_tb.sv
